// ===== src/trc_pkg.sv =====
// Package for the tilt repetition counter: sequencer states, register indexes,
// fixed-point constants and the shared rounding and saturation helpers.
// No dependencies.
`timescale 1ns / 1ps

package trc_pkg;

	localparam int ACC_W = 44;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQ,
		ST_CUBE,
		ST_LIN,
		ST_DEG,
		ST_WR,
		ST_WA,
		ST_FIN
	} state_t;

	localparam logic [1:0] REG_PEAK_THR   = 2'd0;
	localparam logic [1:0] REG_REST_THR   = 2'd1;
	localparam logic [1:0] REG_QUIET_BAND = 2'd2;
	localparam logic [1:0] REG_HOLD       = 2'd3;

	localparam logic [1:0] CLS_NONE = 2'd0;
	localparam logic [1:0] CLS_PEAK = 2'd1;
	localparam logic [1:0] CLS_REST = 2'd2;

	localparam logic signed [23:0] PEAK_THR_RST   = 24'sd12800;
	localparam logic signed [23:0] REST_THR_RST   = 24'sd2560;
	localparam logic [15:0]        QUIET_BAND_RST = 16'd2;
	localparam logic [7:0]         HOLD_RST       = 8'd10;

	localparam logic signed [17:0] R_NEG_ONE = -18'sd65536;
	localparam logic [16:0]        R_ONE_MAG = 17'd65536;
	localparam logic [4:0]         DIV_STEPS = 5'd17;

	// multiplier-side constants, Q16 except C_DEG_SCALE, which is Q24
	localparam logic [23:0] C_CUBE      = 24'd12865;
	localparam logic [23:0] C_DEG_SCALE = 24'd7509879;
	localparam logic [23:0] C_W_ROLL    = 24'd60293;
	localparam logic [23:0] C_W_ACC     = 24'd5243;

	localparam logic signed [17:0] C_LIN     = 18'sd64337;
	localparam logic signed [19:0] C_QTR_PI  = 20'sd51472;
	localparam logic signed [19:0] C_3QTR_PI = 20'sd154415;
	localparam logic signed [19:0] C_PI      = 20'sd205887;

	function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
		if (v > 28'sd8388607)
			return 24'sh7fffff;
		else if (v < -28'sd8388608)
			return 24'sh800000;
		else
			return v[23:0];
	endfunction

	// shifts that truncate toward zero
	function automatic logic signed [ACC_W-1:0] shr16_tz(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] b;
		b = v + (v[ACC_W-1] ? ACC_W'(16'hffff) : {ACC_W{1'b0}});
		return b >>> 16;
	endfunction

	function automatic logic signed [ACC_W-1:0] shr24_tz(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] b;
		b = v + (v[ACC_W-1] ? ACC_W'(24'hffffff) : {ACC_W{1'b0}});
		return b >>> 24;
	endfunction

endpackage

// ===== src/tilt_repetition_counter.sv =====
// Tilt repetition counter top level: bit-serial divider, shift-and-add multiplier,
// sequencer and repetition state. Depends on trc_pkg.
`timescale 1ns / 1ps

// One motion sample in, one word out. A sample runs restoring division for the atan2
// quotient, then six products on one shift-and-add multiplier that retires one
// multiplier bit per cycle and stops once the remaining bits are zero, so the time
// a sample takes follows operand size.
// The first result after reset has angle_value zero and fixes the origin. A finished
// word waits in the output register; the next sample is taken once the block has
// passed its result there.
module tilt_repetition_counter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [23:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  accel_x,
	input  logic signed [15:0]  accel_z,
	input  logic signed [15:0]  gyro_rate,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [23:0]  angle_value,
	output logic [1:0]          sample_class,
	output logic [15:0]         repetitions
);
	import trc_pkg::*;

	state_t state_q, state_d;

	logic signed [23:0] peak_thr_q, rest_thr_q;
	logic [15:0]        band_q;
	logic [7:0]         hold_q;

	logic signed [15:0] ax_q, gyro_q;
	logic               xneg_q, yneg_q, nneg_q, dz_q;
	logic [16:0]        rem_q, dq_q, den_q;
	logic [4:0]         cnt_q;
	logic signed [17:0] r_q;
	logic [16:0]        rmag_q;
	logic signed [ACC_W-1:0] mc_q, acc_q;
	logic [23:0]        mp_q;
	logic signed [23:0] blend_q;

	logic signed [23:0] origin_q;
	logic               origin_taken_q;
	logic [7:0]         peak_run_q, rest_run_q;
	logic               peak_seen_q, rest_seen_q;
	logic [15:0]        rep_q;

	logic               out_valid_q;
	logic signed [23:0] out_angle_q;
	logic [1:0]         out_class_q;
	logic [15:0]        out_rep_q;

	// input front end
	logic               in_fire, xneg_c;
	logic [16:0]        ay_c, nmag_c;
	logic signed [17:0] az18_c, ay18_c, num_c, den_c;

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;

	always_comb begin
		ay_c   = accel_x[15] ? 17'(-$signed({accel_x[15], accel_x})) : 17'({accel_x[15], accel_x});
		az18_c = 18'(accel_z);
		ay18_c = $signed({1'b0, ay_c});
		xneg_c = accel_z[15];
		num_c  = xneg_c ? az18_c + ay18_c : az18_c - ay18_c;
		den_c  = xneg_c ? ay18_c - az18_c : az18_c + ay18_c;
		nmag_c = num_c[17] ? 17'(-num_c) : num_c[16:0];
	end

	// divider step
	logic [17:0] trial_c;
	logic        ge_c;
	logic [16:0] rem_next_c;

	always_comb begin
		trial_c    = {rem_q, dq_q[16]};
		ge_c       = trial_c >= {1'b0, den_q};
		rem_next_c = ge_c ? 17'(trial_c - {1'b0, den_q}) : trial_c[16:0];
	end

	// values formed when a step finishes
	logic                    mul_done;
	logic signed [17:0]      r_c;
	logic [16:0]             rmag_c;
	logic signed [ACC_W-1:0] sh16_c, sh24_c;
	logic signed [17:0]      t_c, tl_c;
	logic signed [19:0]      a_c, ang_c, s_c;
	logic signed [23:0]      blend_c;

	always_comb begin
		mul_done = (mp_q == '0);
		rmag_c   = dz_q ? R_ONE_MAG : dq_q;
		r_c      = dz_q ? R_NEG_ONE :
			(nneg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q}));
		sh16_c   = shr16_tz(acc_q);
		sh24_c   = shr24_tz(acc_q);
		t_c      = 18'(sh16_c) - C_LIN;
		tl_c     = r_q[17] ? -t_c : t_c;
		a_c      = (xneg_q ? C_3QTR_PI : C_QTR_PI) + 20'(sh16_c);
		ang_c    = yneg_q ? -a_c : a_c;
		s_c      = ang_c + C_PI;
		blend_c  = sat24(sh16_c[27:0]);
	end

	// per-sample state update
	logic               fin_go, quiet_c;
	logic signed [23:0] org_c, val_c;
	logic signed [17:0] g18_c, b18_c;
	logic [1:0]         cls_c;
	logic [7:0]         pr_c, rr_c;
	logic               ps_c, rs_c;
	logic [15:0]        rc_c;

	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		org_c   = origin_taken_q ? origin_q : blend_q;
		val_c   = sat24(28'(blend_q) - 28'(org_c));
		g18_c   = 18'(gyro_q);
		b18_c   = $signed({2'b00, band_q});
		quiet_c = (g18_c < b18_c) && (g18_c > -b18_c);
		cls_c   = CLS_NONE;
		if (quiet_c) begin
			if (val_c > peak_thr_q)
				cls_c = CLS_PEAK;
			else if (val_c < rest_thr_q)
				cls_c = CLS_REST;
		end
		pr_c = peak_run_q;
		rr_c = rest_run_q;
		ps_c = peak_seen_q;
		rs_c = rest_seen_q;
		rc_c = rep_q;
		if (cls_c == CLS_PEAK && rs_c && pr_c != 8'hff)
			pr_c = pr_c + 8'd1;
		else if (cls_c == CLS_REST && rr_c != 8'hff)
			rr_c = rr_c + 8'd1;
		if (ps_c && rs_c) begin
			if (rc_c != 16'hffff)
				rc_c = rc_c + 16'd1;
			pr_c = '0;
			rr_c = '0;
			ps_c = 1'b0;
			rs_c = 1'b0;
		end
		if (!ps_c && pr_c >= hold_q && rs_c)
			ps_c = 1'b1;
		if (!rs_c && rr_c >= hold_q)
			rs_c = 1'b1;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_DIV;
			ST_DIV:  if (cnt_q == '0) state_d = ST_SQ;
			ST_SQ:   if (mul_done) state_d = ST_CUBE;
			ST_CUBE: if (mul_done) state_d = ST_LIN;
			ST_LIN:  if (mul_done) state_d = ST_DEG;
			ST_DEG:  if (mul_done) state_d = ST_WR;
			ST_WR:   if (mul_done) state_d = ST_WA;
			ST_WA:   if (mul_done) state_d = ST_FIN;
			ST_FIN:  if (fin_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					ax_q   <= accel_x;
					gyro_q <= gyro_rate;
					xneg_q <= xneg_c;
					yneg_q <= accel_x[15];
					nneg_q <= num_c[17];
					dz_q   <= (den_c == '0);
					den_q  <= den_c[16:0];
					rem_q  <= {1'b0, nmag_c[16:1]};
					dq_q   <= {nmag_c[0], 16'd0};
					cnt_q  <= DIV_STEPS;
				end
			end
			ST_DIV: begin
				if (cnt_q != '0) begin
					rem_q <= rem_next_c;
					dq_q  <= {dq_q[15:0], ge_c};
					cnt_q <= cnt_q - 5'd1;
				end else begin
					r_q    <= r_c;
					rmag_q <= rmag_c;
					mc_q   <= ACC_W'(rmag_c);
					mp_q   <= 24'(rmag_c);
					acc_q  <= '0;
				end
			end
			ST_SQ, ST_CUBE, ST_LIN, ST_DEG, ST_WR, ST_WA: begin
				if (!mul_done) begin
					acc_q <= acc_q + (mp_q[0] ? mc_q : {ACC_W{1'b0}});
					mc_q  <= mc_q <<< 1;
					mp_q  <= mp_q >> 1;
				end else begin
					case (state_q)
						ST_SQ: begin
							mc_q  <= ACC_W'($signed({1'b0, sh16_c[16:0]}));
							mp_q  <= C_CUBE;
							acc_q <= '0;
						end
						ST_CUBE: begin
							mc_q  <= ACC_W'(tl_c);
							mp_q  <= 24'(rmag_q);
							acc_q <= '0;
						end
						ST_LIN: begin
							mc_q  <= ACC_W'(s_c);
							mp_q  <= C_DEG_SCALE;
							acc_q <= '0;
						end
						ST_DEG: begin
							mc_q  <= sh24_c;
							mp_q  <= C_W_ROLL;
							acc_q <= '0;
						end
						ST_WR: begin
							mc_q <= ACC_W'(ax_q) <<< 8;
							mp_q <= C_W_ACC;
						end
						ST_WA: blend_q <= blend_c;
						default: blend_q <= blend_q;
					endcase
				end
			end
			default: blend_q <= blend_q;
		endcase
	end

	// configuration and repetition state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_thr_q     <= PEAK_THR_RST;
			rest_thr_q     <= REST_THR_RST;
			band_q         <= QUIET_BAND_RST;
			hold_q         <= HOLD_RST;
			origin_q       <= '0;
			origin_taken_q <= 1'b0;
			peak_run_q     <= '0;
			rest_run_q     <= '0;
			peak_seen_q    <= 1'b0;
			rest_seen_q    <= 1'b0;
			rep_q          <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PEAK_THR:   peak_thr_q <= cfg_data;
					REG_REST_THR:   rest_thr_q <= cfg_data;
					REG_QUIET_BAND: band_q     <= cfg_data[15:0];
					REG_HOLD:       hold_q     <= cfg_data[7:0];
					default:        hold_q     <= hold_q;
				endcase
			end
			if (fin_go) begin
				origin_q       <= org_c;
				origin_taken_q <= 1'b1;
				peak_run_q     <= pr_c;
				rest_run_q     <= rr_c;
				peak_seen_q    <= ps_c;
				rest_seen_q    <= rs_c;
				rep_q          <= rc_c;
			end
		end
	end

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fin_go)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_angle_q <= val_c;
			out_class_q <= cls_c;
			out_rep_q   <= rc_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign angle_value  = out_angle_q;
	assign sample_class = out_class_q;
	assign repetitions  = out_rep_q;

endmodule

// ===== tb/tilt_repetition_counter_test.sv =====
// Testbench for tilt_repetition_counter: directed table plus random motion samples,
// checked word by word against a behavioral predictor of angle, class and count.
// Depends on trc_pkg and the block itself.
`timescale 1ns / 1ps

module tilt_repetition_counter_test;
	import trc_pkg::*;

	typedef struct {
		logic signed [23:0] angle;
		logic [1:0]         cls;
		logic [15:0]        reps;
	} word_t;

	typedef struct {
		logic signed [15:0] ax;
		logic signed [15:0] az;
		logic signed [15:0] gy;
		bit                 known;
		logic signed [23:0] angle;
		logic [1:0]         cls;
	} row_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [23:0] cfg_data;
	logic in_valid, in_stall;
	logic signed [15:0] accel_x, accel_z, gyro_rate;
	logic out_valid, out_stall;
	logic signed [23:0] angle_value;
	logic [1:0] sample_class;
	logic [15:0] repetitions;

	tilt_repetition_counter DUT (.*);

	// predictor state
	longint peak_thr, rest_thr, quiet_band, hold_n;
	longint origin, peak_run, rest_run, reps;
	bit origin_set, peak_seen, rest_seen;

	word_t expected_words[$];
	int errors;
	bit stall_mode_random, hold_off;
	int idle_cycles;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic longint clip24(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	function automatic longint tilt(longint y, longint x);
		longint ay, num, den, base, r, r2, t, a;
		ay = y < 0 ? -y : y;
		if (x < 0) begin
			num = x + ay; den = ay - x; base = 154415;
		end else begin
			num = x - ay; den = x + ay; base = 51472;
		end
		r = den == 0 ? -65536 : (num * 65536) / den;
		r2 = (r * r) / 65536;
		t = (12865 * r2) / 65536 - 64337;
		a = base + (t * r) / 65536;
		return y < 0 ? -a : a;
	endfunction

	function automatic word_t predict_sample(longint ax, longint az, longint g);
		word_t w;
		longint roll, blend, val;
		logic [1:0] c;
		c = CLS_NONE;
		roll = ((tilt(ax, az) + 205887) * 7509879) / (longint'(1) << 24);
		blend = clip24((60293 * roll + 5243 * ax * 256) / 65536);
		if (!origin_set) begin
			origin = blend;
			origin_set = 1;
		end
		val = clip24(blend - origin);
		if (g < quiet_band && g > -quiet_band) begin
			if (val > peak_thr) c = CLS_PEAK;
			else if (val < rest_thr) c = CLS_REST;
		end
		if (c == CLS_PEAK) begin
			if (rest_seen && peak_run < 255) peak_run++;
		end else if (c == CLS_REST) begin
			if (rest_run < 255) rest_run++;
		end
		if (peak_seen && rest_seen) begin
			if (reps < 65535) reps++;
			peak_run = 0; rest_run = 0; peak_seen = 0; rest_seen = 0;
		end
		if (!peak_seen && peak_run >= hold_n && rest_seen) peak_seen = 1;
		if (!rest_seen && rest_run >= hold_n) rest_seen = 1;
		w.angle = val[23:0];
		w.cls = c;
		w.reps = reps[15:0];
		return w;
	endfunction

	task automatic write_reg(logic [1:0] idx, longint v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v[23:0];
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
		case (idx)
			REG_PEAK_THR:   peak_thr = longint'($signed(v[23:0]));
			REG_REST_THR:   rest_thr = longint'($signed(v[23:0]));
			REG_QUIET_BAND: quiet_band = v & 16'hffff;
			REG_HOLD:       hold_n = v & 8'hff;
			default: ;
		endcase
	endtask

	task automatic drain;
		in_valid <= 0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// one sample; the predictor runs on acceptance
	task automatic send(logic signed [15:0] ax, logic signed [15:0] az,
			logic signed [15:0] gy, bit known, logic signed [23:0] ang, logic [1:0] c);
		word_t w;
		while (stall_mode_random && $urandom_range(99) < 34) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		accel_x <= ax;
		accel_z <= az;
		gyro_rate <= gy;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		w = predict_sample(ax, az, gy);
		if (known && w.angle !== ang) begin
			$error("directed angle_value expected %0d actual %0d", ang, w.angle);
			errors++;
		end
		if (known && w.cls !== c) begin
			$error("directed sample_class expected %0d actual %0d", c, w.cls);
			errors++;
		end
		expected_words.push_back(w);
	endtask

	task automatic random_sample(int mode);
		logic signed [15:0] ax, az, gy;
		ax = 16'($urandom); az = 16'($urandom); gy = 16'($urandom);
		if (mode == 0) begin
			// well-formed motion: quiet gyro, swing between lying and raised
			gy = $signed(16'($urandom_range(0, 4))) - 16'sd2;
			if ($urandom_range(1)) begin
				ax = 16'($urandom_range(0, 800)); az = 16'sd16000;
			end else begin
				ax = 16'sd16000 + 16'($urandom_range(0, 800));
				az = $signed(16'($urandom_range(0, 3000))) - 16'sd1500;
			end
		end
		send(ax, az, gy, 0, 0, 0);
	endtask

	// output side
	always @(posedge clk) begin
		word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word: angle %0d", angle_value);
				errors++;
			end else begin
				w = expected_words.pop_front();
				if (angle_value !== w.angle) begin
					$error("angle_value expected %0d actual %0d", w.angle, angle_value);
					errors++;
				end
				if (sample_class !== w.cls) begin
					$error("sample_class expected %0d actual %0d", w.cls, sample_class);
					errors++;
				end
				if (repetitions !== w.reps) begin
					$error("repetitions expected %0d actual %0d", w.reps, repetitions);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_off) out_stall <= 1;
		else out_stall <= stall_mode_random ? ($urandom_range(99) < 34) : 1'b0;
	end

	// watchdog: cycles with nothing accepted
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	row_t rows[$];

	initial begin
		errors = 0; idle_cycles = 0; hold_off = 0; stall_mode_random = 0;
		arst_n = 0; cfg_we = 0; cfg_index = REG_PEAK_THR; cfg_data = 0;
		in_valid = 0; accel_x = 0; accel_z = 0; gyro_rate = 0; out_stall = 0;
		peak_thr = 12800; rest_thr = 2560; quiet_band = 2; hold_n = 10;
		origin = 0; origin_set = 0; peak_run = 0; rest_run = 0; reps = 0;
		peak_seen = 0; rest_seen = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// first word fixes the origin, so angle is zero; it is a rest below threshold
		rows.push_back('{16'sd0, 16'sd0, 16'sd0, 1, 24'sd0, CLS_REST});
		rows.push_back('{16'sd0, 16'sd16384, 16'sd1, 0, 0, 0});
		rows.push_back('{16'sd32767, 16'sd0, -16'sd1, 0, 0, 0});
		rows.push_back('{-16'sd32768, 16'sd0, 16'sd0, 0, 0, 0});
		rows.push_back('{-16'sd32768, -16'sd32768, 16'sd32767, 1, 0, CLS_NONE});
		rows.push_back('{16'sd32767, 16'sd32767, -16'sd32768, 1, 0, CLS_NONE});
		rows.push_back('{16'sd0, -16'sd32768, 16'sd2, 0, 0, 0});
		rows.push_back('{-16'sd1, 16'sd1, -16'sd2, 0, 0, 0});
		rows.push_back('{16'sd1, -16'sd1, 16'sd0, 0, 0, 0});
		rows.push_back('{16'sd0, 16'sd0, 16'sd0, 0, 0, 0});
		foreach (rows[i]) begin
			if (rows[i].known && rows[i].cls != CLS_NONE) rows[i].angle = 0;
			if (rows[i].known && rows[i].cls == CLS_NONE) begin
				send(rows[i].ax, rows[i].az, rows[i].gy, 0, 0, 0);
			end else begin
				send(rows[i].ax, rows[i].az, rows[i].gy, rows[i].known,
					rows[i].angle, rows[i].cls);
			end
		end
		drain();

		// hold count zero and a wide band: flags set without marked samples
		write_reg(REG_HOLD, 0);
		write_reg(REG_QUIET_BAND, 32768);
		for (int i = 0; i < 12; i++) random_sample(i % 2);
		drain();

		// band zero: nothing is classed
		write_reg(REG_QUIET_BAND, 0);
		write_reg(REG_PEAK_THR, 24'h800000);
		write_reg(REG_REST_THR, 24'h7fffff);
		for (int i = 0; i < 6; i++) random_sample(1);
		drain();

		// pressure: receiver holds off while the sender keeps offering
		write_reg(REG_QUIET_BAND, 3);
		write_reg(REG_PEAK_THR, 1500);
		write_reg(REG_REST_THR, -1500);
		write_reg(REG_HOLD, 2);
		fork
			begin
				hold_off = 1;
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 8; i++) random_sample(0);
		join
		drain();

		// random phases across several settings, a quiet stretch first
		for (int ph = 0; ph < 5; ph++) begin
			stall_mode_random = ph != 0;
			case (ph)
				1: write_reg(REG_HOLD, 255);
				2: write_reg(REG_HOLD, 1);
				3: begin
					write_reg(REG_PEAK_THR, 24'h7fffff);
					write_reg(REG_REST_THR, 24'h800000);
				end
				4: begin
					write_reg(REG_PEAK_THR, 12800);
					write_reg(REG_REST_THR, 2560);
					write_reg(REG_QUIET_BAND, 2);
					write_reg(REG_HOLD, 3);
				end
				default: ;
			endcase
			for (int i = 0; i < 200; i++) random_sample($urandom_range(99) < 80 ? 0 : 1);
			stall_mode_random = 0;
			drain();
		end

		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

// ===== tilt_repetition_counter.f =====
src/trc_pkg.sv
src/tilt_repetition_counter.sv
tb/tilt_repetition_counter_test.sv
